// ===== rtl/rv32ie_pkg.sv =====
package rv32ie_pkg;

   localparam int DMEM_WORDS = 4096;
   localparam int DMEM_AW    = $clog2(DMEM_WORDS);
   localparam logic [32:0] DMEM_BYTES = 33'(4 * DMEM_WORDS);

   localparam int REQ_W = 80;
   localparam int RSP_W = 80;

   localparam logic [6:0] OPC_LUI    = 7'b0110111;
   localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
   localparam logic [6:0] OPC_JAL    = 7'b1101111;
   localparam logic [6:0] OPC_JALR   = 7'b1100111;
   localparam logic [6:0] OPC_BRANCH = 7'b1100011;
   localparam logic [6:0] OPC_LOAD   = 7'b0000011;
   localparam logic [6:0] OPC_STORE  = 7'b0100011;
   localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
   localparam logic [6:0] OPC_OP     = 7'b0110011;
   localparam logic [6:0] OPC_FENCE  = 7'b0001111;
   localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_ILLEGAL  = 3'd1;
   localparam logic [2:0] STAT_ECALL    = 3'd2;
   localparam logic [2:0] STAT_EBREAK   = 3'd3;
   localparam logic [2:0] STAT_PCRANGE  = 3'd4;
   localparam logic [2:0] STAT_MEMRANGE = 3'd5;

   localparam logic CSR_START_PC = 1'b0;
   localparam logic CSR_PC_LIMIT = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE, S_PRELOAD, S_DECODE, S_RD0, S_RD1, S_RD2, S_LOAD_WB,
      S_WR0, S_WR1, S_MUL, S_MUL_WB, S_DIV, S_DIV_WB, S_FINISH
   } state_type;

   typedef enum logic [2:0] {
      K_SIMPLE, K_LOAD, K_STORE, K_MUL, K_DIV
   } kind_type;

   typedef struct packed {
      logic accept;
      logic preload;
      logic decode;
      logic rd_hi;
      logic cap_lo;
      logic cap_hi;
      logic load_wb;
      logic wr_lo;
      logic wr_hi;
      logic mul;
      logic mul_wb;
      logic div_step;
      logic div_wb;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      kind_type dec_kind;
      kind_type kind;
      logic     spans;
      logic     div_last;
      logic     rsp_free;
   } ctl_sts_type;

endpackage

// ===== rtl/rv32ie_ram.sv =====
module rv32ie_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/rv32ie_ctrl.sv =====
module rv32ie_ctrl
   import rv32ie_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tuser,
   output logic        req_tready,
   input  ctl_sts_type sts,
   output ctl_cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = req_tuser ? S_PRELOAD : S_DECODE;
            end
         end
         S_PRELOAD: state_in = S_FINISH;
         S_DECODE: begin
            case (sts.dec_kind)
               K_LOAD, K_STORE: state_in = S_RD0;
               K_MUL:           state_in = S_MUL;
               K_DIV:           state_in = S_DIV;
               default:         state_in = S_FINISH;
            endcase
         end
         S_RD0:     state_in = S_RD1;
         S_RD1:     state_in = S_RD2;
         S_RD2:     state_in = (sts.kind == K_LOAD) ? S_LOAD_WB : S_WR0;
         S_LOAD_WB: state_in = S_FINISH;
         S_WR0:     state_in = sts.spans ? S_WR1 : S_FINISH;
         S_WR1:     state_in = S_FINISH;
         S_MUL:     state_in = S_MUL_WB;
         S_MUL_WB:  state_in = S_FINISH;
         S_DIV:     state_in = sts.div_last ? S_DIV_WB : S_DIV;
         S_DIV_WB:  state_in = S_FINISH;
         S_FINISH: begin
            if (sts.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready   = (state_ff == S_IDLE);
      cmd          = '0;
      cmd.accept   = req_tvalid && (state_ff == S_IDLE);
      cmd.preload  = (state_ff == S_PRELOAD);
      cmd.decode   = (state_ff == S_DECODE);
      cmd.rd_hi    = (state_ff == S_RD1);
      cmd.cap_lo   = (state_ff == S_RD1);
      cmd.cap_hi   = (state_ff == S_RD2);
      cmd.load_wb  = (state_ff == S_LOAD_WB);
      cmd.wr_lo    = (state_ff == S_WR0);
      cmd.wr_hi    = (state_ff == S_WR1);
      cmd.mul      = (state_ff == S_MUL);
      cmd.mul_wb   = (state_ff == S_MUL_WB);
      cmd.div_step = (state_ff == S_DIV);
      cmd.div_wb   = (state_ff == S_DIV_WB);
      cmd.finish   = (state_ff == S_FINISH) && sts.rsp_free;
   end

endmodule

// ===== rtl/rv32ie_dp.sv =====
module rv32ie_dp
   import rv32ie_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tuser,
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_wen,
   input  logic             csr_index,
   input  logic [31:0]      csr_wdata,
   input  ctl_cmd_type      cmd,
   output ctl_sts_type      sts
);

   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;
   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;
   localparam logic [6:0] F7_MDIV = 7'h01;
   localparam logic [31:0] INST_ECALL  = 32'h0000_0073;
   localparam logic [31:0] INST_EBREAK = 32'h0010_0073;

   // item and architectural state
   logic        op_ff;
   logic [31:0] inst_ff, word_ff;
   logic [11:0] idx_ff;
   logic [31:0] pc_ff, limit_ff;
   logic [31:0] rf_valid_ff;

   // decode results
   logic [2:0]  stat_ff;
   logic        wr_ff;
   logic [31:0] val_ff, npc_ff, addr_ff, opa_ff, opb_ff;
   kind_type    kind_ff;

   // memory window, multiplier, divider
   logic [31:0] lo_ff, hi_ff;
   logic signed [65:0] prod_ff;
   logic [31:0] quo_ff, rem_ff, dvs_ff;
   logic [4:0]  cnt_ff;
   logic        neg_q_ff, neg_r_ff, bz_ff;

   logic             rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;

   logic [31:0] rf_a_rd, rf_b_rd, a_val, b_val;
   logic [31:0] dmem_rd, dmem_wdata;
   logic [DMEM_AW-1:0] w0, w1, dmem_waddr;
   logic        dmem_wen, idx_ok;

   logic [6:0]  opcode, f7;
   logic [2:0]  f3;
   logic [4:0]  rd;
   logic [31:0] immi, imms, immb, immj, immu, eaddr;
   logic [2:0]  nbytes;
   logic        mem_ok;
   logic [2:0]  d_stat;
   logic        d_wr;
   logic [31:0] d_val, d_npc;
   kind_type    d_kind;

   logic [63:0] window, shifted, st_data, merged;
   logic [7:0]  st_mask;
   logic [31:0] ld_val;

   logic [32:0] rem_sh;
   logic [33:0] diff;

   logic [2:0]  fin_stat;
   logic        fin_wr;
   logic [31:0] fin_npc;
   logic        rsp_free;

   assign opcode = inst_ff[6:0];
   assign rd     = inst_ff[11:7];
   assign f3     = inst_ff[14:12];
   assign f7     = inst_ff[31:25];
   assign immi   = {{20{inst_ff[31]}}, inst_ff[31:20]};
   assign imms   = {{20{inst_ff[31]}}, inst_ff[31:25], inst_ff[11:7]};
   assign immb   = {{19{inst_ff[31]}}, inst_ff[31], inst_ff[7], inst_ff[30:25],
                    inst_ff[11:8], 1'b0};
   assign immj   = {{11{inst_ff[31]}}, inst_ff[31], inst_ff[19:12], inst_ff[20],
                    inst_ff[30:21], 1'b0};
   assign immu   = {inst_ff[31:12], 12'b0};

   // register file: two copies for two read ports, valid bits give reset zeros
   rv32ie_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
      .clock   (clock),
      .wr_en   (cmd.finish && fin_wr),
      .wr_addr (rd),
      .wr_data (val_ff),
      .rd_addr (req_tdata[19:15]),
      .rd_data (rf_a_rd)
   );

   rv32ie_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
      .clock   (clock),
      .wr_en   (cmd.finish && fin_wr),
      .wr_addr (rd),
      .wr_data (val_ff),
      .rd_addr (req_tdata[24:20]),
      .rd_data (rf_b_rd)
   );

   assign a_val = rf_valid_ff[inst_ff[19:15]] ? rf_a_rd : 32'b0;
   assign b_val = rf_valid_ff[inst_ff[24:20]] ? rf_b_rd : 32'b0;

   // decode and single-cycle ALU
   assign eaddr  = a_val + ((opcode == OPC_STORE) ? imms : immi);
   assign nbytes = 3'd1 << f3[1:0];
   assign mem_ok = ({1'b0, eaddr} + 33'(nbytes)) <= DMEM_BYTES;

   always_comb begin
      d_stat = STAT_OK;
      d_wr   = 1'b0;
      d_val  = 32'b0;
      d_npc  = pc_ff + 32'd4;
      d_kind = K_SIMPLE;
      if (pc_ff >= limit_ff) begin
         d_stat = STAT_PCRANGE;
      end else begin
         case (opcode)
            OPC_LUI: begin
               d_wr  = 1'b1;
               d_val = immu;
            end
            OPC_AUIPC: begin
               d_wr  = 1'b1;
               d_val = pc_ff + immu;
            end
            OPC_JAL: begin
               d_wr  = 1'b1;
               d_val = pc_ff + 32'd4;
               d_npc = pc_ff + immj;
            end
            OPC_JALR: begin
               if (f3 != 3'd0) begin
                  d_stat = STAT_ILLEGAL;
               end else begin
                  d_wr  = 1'b1;
                  d_val = pc_ff + 32'd4;
                  d_npc = (a_val + immi) & ~32'd1;
               end
            end
            OPC_BRANCH: begin
               case (f3)
                  F3_BEQ:  if (a_val == b_val) d_npc = pc_ff + immb;
                  F3_BNE:  if (a_val != b_val) d_npc = pc_ff + immb;
                  F3_BLT:  if ($signed(a_val) < $signed(b_val)) d_npc = pc_ff + immb;
                  F3_BGE:  if ($signed(a_val) >= $signed(b_val)) d_npc = pc_ff + immb;
                  F3_BLTU: if (a_val < b_val) d_npc = pc_ff + immb;
                  F3_BGEU: if (a_val >= b_val) d_npc = pc_ff + immb;
                  default: d_stat = STAT_ILLEGAL;
               endcase
            end
            OPC_LOAD: begin
               if (f3[1:0] == 2'b11 || f3 == 3'd6) begin
                  d_stat = STAT_ILLEGAL;
               end else if (!mem_ok) begin
                  d_stat = STAT_MEMRANGE;
               end else begin
                  d_wr   = 1'b1;
                  d_kind = K_LOAD;
               end
            end
            OPC_STORE: begin
               if (f3 > 3'd2) begin
                  d_stat = STAT_ILLEGAL;
               end else if (!mem_ok) begin
                  d_stat = STAT_MEMRANGE;
               end else begin
                  d_kind = K_STORE;
               end
            end
            OPC_OPIMM: begin
               d_wr = 1'b1;
               case (f3)
                  F3_ADD:  d_val = a_val + immi;
                  F3_SLT:  d_val = {31'b0, $signed(a_val) < $signed(immi)};
                  F3_SLTU: d_val = {31'b0, a_val < immi};
                  F3_XOR:  d_val = a_val ^ immi;
                  F3_OR:   d_val = a_val | immi;
                  F3_AND:  d_val = a_val & immi;
                  F3_SLL: begin
                     if (f7 != F7_BASE) d_stat = STAT_ILLEGAL;
                     else d_val = a_val << inst_ff[24:20];
                  end
                  default: begin
                     if (f7 == F7_BASE) d_val = a_val >> inst_ff[24:20];
                     else if (f7 == F7_ALT) d_val = 32'($signed(a_val) >>> inst_ff[24:20]);
                     else d_stat = STAT_ILLEGAL;
                  end
               endcase
            end
            OPC_OP: begin
               d_wr = 1'b1;
               if (f7 == F7_MDIV) begin
                  d_kind = f3[2] ? K_DIV : K_MUL;
               end else if (f7 == F7_ALT) begin
                  if (f3 == F3_ADD) d_val = a_val - b_val;
                  else if (f3 == F3_SR) d_val = 32'($signed(a_val) >>> b_val[4:0]);
                  else d_stat = STAT_ILLEGAL;
               end else if (f7 != F7_BASE) begin
                  d_stat = STAT_ILLEGAL;
               end else begin
                  case (f3)
                     F3_ADD:  d_val = a_val + b_val;
                     F3_SLL:  d_val = a_val << b_val[4:0];
                     F3_SLT:  d_val = {31'b0, $signed(a_val) < $signed(b_val)};
                     F3_SLTU: d_val = {31'b0, a_val < b_val};
                     F3_XOR:  d_val = a_val ^ b_val;
                     F3_SR:   d_val = a_val >> b_val[4:0];
                     F3_OR:   d_val = a_val | b_val;
                     default: d_val = a_val & b_val;
                  endcase
               end
            end
            OPC_FENCE: begin
               if (f3 != 3'd0) d_stat = STAT_ILLEGAL;
            end
            OPC_SYSTEM: begin
               if (inst_ff == INST_ECALL) d_stat = STAT_ECALL;
               else if (inst_ff == INST_EBREAK) d_stat = STAT_EBREAK;
               else d_stat = STAT_ILLEGAL;
            end
            default: d_stat = STAT_ILLEGAL;
         endcase
      end
      if (d_stat != STAT_OK) begin
         d_kind = K_SIMPLE;
         d_wr   = 1'b0;
      end
   end

   // data memory: a two-word window serves misaligned accesses
   assign w0     = addr_ff[DMEM_AW+1:2];
   assign w1     = w0 + DMEM_AW'(1);
   assign idx_ok = 32'(idx_ff) < 32'(DMEM_WORDS);

   assign window  = {hi_ff, lo_ff};
   assign shifted = window >> {addr_ff[1:0], 3'b000};
   assign st_mask = 8'(nbytes == 3'd1 ? 8'h01 : (nbytes == 3'd2 ? 8'h03 : 8'h0f))
                    << addr_ff[1:0];
   assign st_data = {32'b0, opb_ff} << {addr_ff[1:0], 3'b000};

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         merged[i*8 +: 8] = st_mask[i] ? st_data[i*8 +: 8] : window[i*8 +: 8];
      end
   end

   always_comb begin
      case (f3[1:0])
         2'b00:   ld_val = {{24{shifted[7] & ~f3[2]}}, shifted[7:0]};
         2'b01:   ld_val = {{16{shifted[15] & ~f3[2]}}, shifted[15:0]};
         default: ld_val = shifted[31:0];
      endcase
   end

   assign dmem_wen   = (cmd.preload && idx_ok) || cmd.wr_lo || cmd.wr_hi;
   assign dmem_waddr = cmd.preload ? DMEM_AW'(idx_ff) : (cmd.wr_hi ? w1 : w0);
   assign dmem_wdata = cmd.preload ? word_ff : (cmd.wr_hi ? merged[63:32] : merged[31:0]);

   rv32ie_ram #(.WIDTH(32), .DEPTH(DMEM_WORDS)) u_dmem (
      .clock   (clock),
      .wr_en   (dmem_wen),
      .wr_addr (dmem_waddr),
      .wr_data (dmem_wdata),
      .rd_addr (cmd.rd_hi ? w1 : w0),
      .rd_data (dmem_rd)
   );

   // divider step: restoring, one quotient bit per cycle
   assign rem_sh = {rem_ff, quo_ff[31]};
   assign diff   = {1'b0, rem_sh} - {2'b0, dvs_ff};

   // retire
   always_comb begin
      fin_npc  = pc_ff;
      fin_stat = stat_ff;
      fin_wr   = 1'b0;
      if (!op_ff && stat_ff == STAT_OK) begin
         fin_npc  = npc_ff;
         fin_stat = (npc_ff >= limit_ff) ? STAT_PCRANGE : STAT_OK;
         fin_wr   = wr_ff && (rd != 5'd0);
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      sts          = '0;
      sts.dec_kind = d_kind;
      sts.kind     = kind_ff;
      sts.spans    = ({1'b0, addr_ff[1:0]} + nbytes) > 3'd4;
      sts.div_last = (cnt_ff == 5'd31);
      sts.rsp_free = rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= 32'b0;
         limit_ff     <= 32'hffff_ffff;
         rf_valid_ff  <= 32'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            if (csr_index == CSR_START_PC) begin
               pc_ff <= csr_wdata;
            end else begin
               limit_ff <= csr_wdata;
            end
         end
         if (cmd.finish) begin
            pc_ff <= fin_npc;
            if (fin_wr) begin
               rf_valid_ff[rd] <= 1'b1;
            end
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= req_tuser;
         inst_ff <= req_tdata[31:0];
         idx_ff  <= req_tdata[43:32];
         word_ff <= req_tdata[75:44];
      end
      if (cmd.preload) begin
         stat_ff <= idx_ok ? STAT_OK : STAT_MEMRANGE;
         wr_ff   <= 1'b0;
      end
      if (cmd.decode) begin
         stat_ff  <= d_stat;
         wr_ff    <= d_wr;
         val_ff   <= d_val;
         npc_ff   <= d_npc;
         kind_ff  <= d_kind;
         addr_ff  <= eaddr;
         opa_ff   <= a_val;
         opb_ff   <= b_val;
         neg_q_ff <= !f3[0] && (a_val[31] ^ b_val[31]);
         neg_r_ff <= !f3[0] && a_val[31];
         bz_ff    <= (b_val == 32'b0);
         quo_ff   <= (!f3[0] && a_val[31]) ? -a_val : a_val;
         dvs_ff   <= (!f3[0] && b_val[31]) ? -b_val : b_val;
         rem_ff   <= 32'b0;
         cnt_ff   <= 5'd0;
      end
      if (cmd.cap_lo) lo_ff <= dmem_rd;
      if (cmd.cap_hi) hi_ff <= dmem_rd;
      if (cmd.load_wb) val_ff <= ld_val;
      if (cmd.mul) begin
         prod_ff <= $signed({(f3 == 3'd1 || f3 == 3'd2) && opa_ff[31], opa_ff})
                  * $signed({(f3 == 3'd1) && opb_ff[31], opb_ff});
      end
      if (cmd.mul_wb) begin
         val_ff <= (f3[1:0] == 2'b00) ? prod_ff[31:0] : prod_ff[63:32];
      end
      if (cmd.div_step) begin
         cnt_ff <= cnt_ff + 5'd1;
         if (!diff[33]) begin
            rem_ff <= diff[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[31:0];
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
      if (cmd.div_wb) begin
         if (f3[1]) val_ff <= neg_r_ff ? -rem_ff : rem_ff;
         else if (bz_ff) val_ff <= 32'hffff_ffff;
         else val_ff <= neg_q_ff ? -quo_ff : quo_ff;
      end
      if (cmd.finish) begin
         rsp_data_ff <= {7'b0, fin_stat, fin_wr ? val_ff : 32'b0,
                         fin_wr ? rd : 5'd0, fin_wr, fin_npc};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/rv32im_instruction_executor.sv =====
// RV32IM execute unit: one instruction or one data preload per input beat.
// Loads read a two-word memory window; stores read it and write back one or
// two words (read-modify-write); multiplies take a product step and a write-back
// step; divide/remainder produces one quotient bit per cycle.
// One beat in flight at a time; the result register frees the input side.
// Synchronous reset: registers read zero, pc = 0, pc limit all ones.
module rv32im_instruction_executor
   import rv32ie_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // input beats
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_tuser,   // operation: 0 execute, 1 preload
   input  logic [REQ_W-1:0] req_tdata,   // instruction[31:0], preload_index[43:32],
                                         // preload_word[75:44], zero pad
   // result beats
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // next_pc[31:0], reg_write[32],
                                         // dest_reg[37:33], dest_value[69:38],
                                         // status[72:70], zero pad
   // configuration: 0 start_pc (also loads pc), 1 pc_limit
   input  logic             csr_wen,
   input  logic             csr_index,
   input  logic [31:0]      csr_wdata
);

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   // sequencer: decode, memory window read/write, mul and divide steps
   rv32ie_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // register file, data memory, ALU, multiplier, divider, result register
   rv32ie_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule
